@@ hw/rtl/sgvc_pkg.sv @@
// sky gradient vertex color: shared constants, register codes, structs and helpers
// no dependencies; imported by every module of the block

package sgvc_pkg;

  // default widths handed to the top level
  localparam int COLOR_BITS_DEF = 8;
  localparam int ANGLE_BITS_DEF = 16;

  // fixed widths
  localparam int FRAC_W     = 17;       // 16-bit fraction that can also hold 1.0
  localparam int DIV_STAGES = FRAC_W;   // one quotient bit per divider stage
  localparam int SEED_W     = 16;       // upper part of the dividend
  localparam int NUM_W      = SEED_W + FRAC_W;
  localparam int CFG_IDX_W  = 3;
  localparam int ALT_W      = 16;
  localparam int AZI_W      = 17;
  localparam int CUT_W      = 17;
  localparam int NUM_CH     = 3;

  // arithmetic constants
  localparam logic [FRAC_W-1:0] ONE16      = 17'd65536;
  localparam logic [FRAC_W-1:0] ROUND_HALF = 17'd32768;
  localparam logic [FRAC_W-1:0] NIGHT_FADE = 17'd9830;
  localparam logic [ALT_W-1:0]  TWI_LIMIT  = 16'd1280;
  localparam logic [AZI_W-1:0]  SUNSET_AZI = 17'd46080;
  localparam int                SLOPE_W    = 15;
  localparam logic [SLOPE_W-1:0] FADE_SLOPE = 15'd27853;  // 55706 / 2 over 1280

  // divide by five through a reciprocal, exact for every 19-bit input
  localparam int                  DIV5_IN_W  = 19;
  localparam logic [DIV5_IN_W-1:0] DIV5_MUL  = 19'd419431;
  localparam int                  DIV5_SHIFT = 21;

  // register reset values
  localparam logic [23:0]      HORIZON_RST = 24'hB3D9FF;
  localparam logic [23:0]      ZENITH_RST  = 24'h1F52B3;
  localparam logic [23:0]      GLOW_RST    = 24'hFF8C00;
  localparam logic [CUT_W-1:0] CUTOFF_RST  = 17'd19661;

  // configuration register indexes
  typedef enum logic [CFG_IDX_W-1:0] {
    REG_HORIZON = 3'd0,
    REG_ZENITH  = 3'd1,
    REG_GLOW    = 3'd2,
    REG_CUTOFF  = 3'd3,
    REG_SUN_ALT = 3'd4,
    REG_SUN_AZI = 3'd5
  } cfg_reg_t;

  // scalar configuration as seen by the datapath
  typedef struct packed {
    logic [CUT_W-1:0] cutoff;   // zero already replaced by one
    logic [ALT_W-1:0] sun_alt;
    logic [AZI_W-1:0] sun_azi;
  } cfg_t;

  // per-vertex weights that ride alongside the divider
  typedef struct packed {
    logic              grad;
    logic              glow;
    logic [FRAC_W-1:0] fade;
    logic [FRAC_W-1:0] weight;
  } side_t;

  // front end result: weights plus the dividend
  typedef struct packed {
    side_t             side;
    logic [SEED_W-1:0] seed;
    logic [FRAC_W-1:0] low;
  } front_t;

  // one divider stage
  typedef struct packed {
    logic [FRAC_W-1:0] rem;
    logic [FRAC_W-1:0] low;
    logic [FRAC_W-1:0] quo;
    side_t             side;
  } div_stage_t;

  // floor(y / 5)
  function automatic logic [FRAC_W-1:0] div5(input logic [DIV5_IN_W-1:0] y);
    logic [2*DIV5_IN_W-1:0] prod;
    prod = y * DIV5_MUL;
    return prod[DIV5_SHIFT +: FRAC_W];
  endfunction

endpackage

@@ hw/rtl/sgvc_cfg.sv @@
// sky gradient vertex color: configuration register file
// depends on sgvc_pkg

module sgvc_cfg import sgvc_pkg::*; #(
  parameter int COLOR_BITS = COLOR_BITS_DEF,
  parameter int CFG_W      = 3 * COLOR_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    cfg_valid,
  input  logic [CFG_IDX_W-1:0]    cfg_index,
  input  logic [CFG_W-1:0]        cfg_data,
  output logic [3*COLOR_BITS-1:0] horizon,
  output logic [3*COLOR_BITS-1:0] zenith,
  output logic [3*COLOR_BITS-1:0] glow_rgb,
  output cfg_t                    cfg
);

  localparam int CW = 3 * COLOR_BITS;

  logic [CW-1:0]    horizon_r, zenith_r, glow_r;
  logic [CUT_W-1:0] cutoff_r;
  logic [ALT_W-1:0] sun_alt_r;
  logic [AZI_W-1:0] sun_azi_r;

  // register writes, unknown indexes dropped
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      horizon_r <= CW'(HORIZON_RST);
      zenith_r  <= CW'(ZENITH_RST);
      glow_r    <= CW'(GLOW_RST);
      cutoff_r  <= CUTOFF_RST;
      sun_alt_r <= '0;
      sun_azi_r <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        REG_HORIZON: horizon_r <= cfg_data[CW-1:0];
        REG_ZENITH:  zenith_r  <= cfg_data[CW-1:0];
        REG_GLOW:    glow_r    <= cfg_data[CW-1:0];
        REG_CUTOFF:  cutoff_r  <= cfg_data[CUT_W-1:0];
        REG_SUN_ALT: sun_alt_r <= cfg_data[ALT_W-1:0];
        REG_SUN_AZI: sun_azi_r <= cfg_data[AZI_W-1:0];
        default: ;
      endcase
    end
  end

  assign horizon  = horizon_r;
  assign zenith   = zenith_r;
  assign glow_rgb = glow_r;

  // zero cutoff behaves as the smallest step
  assign cfg.cutoff  = (cutoff_r == '0) ? CUT_W'(1) : cutoff_r;
  assign cfg.sun_alt = sun_alt_r;
  assign cfg.sun_azi = sun_azi_r;

endmodule

@@ hw/rtl/sgvc_front.sv @@
// sky gradient vertex color: four-stage front end
// folds the elevation, builds the dividend, fade and glow weight; depends on sgvc_pkg

module sgvc_front import sgvc_pkg::*; #(
  parameter int ANGLE_BITS = ANGLE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  en,
  input  logic                  in_valid,
  input  logic [ANGLE_BITS-1:0] elev,
  input  logic [ANGLE_BITS-1:0] bear,
  input  cfg_t                  cfg,
  output logic                  out_valid,
  output front_t                out_data
);

  localparam int A      = ANGLE_BITS;
  localparam int PROD_W = 27;
  localparam logic [A-1:0] QA = A'(1 << (A - 2));

  // stage 1: fold angles, sun altitude terms
  logic [A-1:0]        ae, ab, u_full;
  logic signed [A:0]   dd;
  logic [A:0]          dd_mag;
  logic [ALT_W-1:0]    aa;
  logic                twi;
  logic [11:0]         alt_ofs;

  logic                v1_r;
  logic [A-2:0]        u1_r;
  logic [A-1:0]        ab1_r;
  logic                twi1_r, night1_r, day1_r, sunset1_r;
  logic [PROD_W-1:0]   fprod1_r;
  logic [10:0]         mz1_r;

  always_comb begin
    ae      = elev[A-1] ? (~elev + 1'b1) : elev;
    ab      = bear[A-1] ? (~bear + 1'b1) : bear;
    dd      = $signed({1'b0, QA}) - $signed({1'b0, ae});
    dd_mag  = dd[A] ? (~dd + 1'b1) : dd;
    u_full  = QA - dd_mag[A-1:0];
    aa      = cfg.sun_alt[ALT_W-1] ? (~cfg.sun_alt + 1'b1) : cfg.sun_alt;
    twi     = aa <= TWI_LIMIT;
    alt_ofs = 12'(cfg.sun_alt + TWI_LIMIT);
  end

  always_ff @(posedge clk) begin
    if (en) begin
      u1_r      <= u_full[A-2:0];
      ab1_r     <= ab;
      twi1_r    <= twi;
      night1_r  <= cfg.sun_alt[ALT_W-1] & ~twi;
      day1_r    <= ~cfg.sun_alt[ALT_W-1] & ~twi;
      sunset1_r <= cfg.sun_azi > SUNSET_AZI;
      fprod1_r  <= PROD_W'(alt_ofs) * PROD_W'(FADE_SLOPE);
      mz1_r     <= 11'(TWI_LIMIT - aa);
    end
  end

  // stage 2: gradient test, glow side, fractions, fade
  logic [A+15:0]       grad_lhs, grad_rhs, a_sh, b_sh;
  logic [A-1:0]        w_full, a_diff;
  logic                side_ok, low_half;
  logic [NUM_W-1:0]    num;
  logic [FRAC_W-1:0]   fade_nxt;

  logic                v2_r, grad2_r, glow2_r;
  logic [FRAC_W-1:0]   fade2_r, a16_2_r, b16_2_r, m16_2_r;
  logic [SEED_W-1:0]   seed2_r;
  logic [FRAC_W-1:0]   low2_r;

  always_comb begin
    grad_lhs = (A+16)'(u1_r) << 16;
    grad_rhs = (A+16)'(cfg.cutoff) << (A - 2);
    low_half = {u1_r, 1'b0} <= QA;
    side_ok  = sunset1_r ? (ab1_r > QA) : (ab1_r <= QA);
    w_full   = sunset1_r ? (ab1_r - QA) : (QA - ab1_r);
    a_diff   = QA - {u1_r, 1'b0};
    a_sh     = ((A+16)'(a_diff) << 16) >> (A - 2);
    b_sh     = ((A+16)'(w_full[A-2:0]) << 16) >> (A - 2);
    num      = NUM_W'(u1_r) << (34 - A);
    if (night1_r) begin
      fade_nxt = NIGHT_FADE;
    end else if (day1_r) begin
      fade_nxt = ONE16;
    end else begin
      fade_nxt = NIGHT_FADE + div5(fprod1_r[PROD_W-1:8]);
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      grad2_r <= grad_lhs <= grad_rhs;
      glow2_r <= twi1_r & low_half & side_ok;
      fade2_r <= fade_nxt;
      a16_2_r <= a_sh[FRAC_W-1:0];
      b16_2_r <= b_sh[FRAC_W-1:0];
      m16_2_r <= div5({mz1_r, 8'b0});
      seed2_r <= num[NUM_W-1 -: SEED_W];
      low2_r  <= num[FRAC_W-1:0];
    end
  end

  // stage 3: elevation weight times twilight weight
  logic [2*FRAC_W-1:0] am_prod;
  logic                v3_r;
  logic [FRAC_W-1:0]   am3_r;
  front_t              f3_r;
  logic [FRAC_W-1:0]   b16_3_r;

  assign am_prod = a16_2_r * m16_2_r;

  always_ff @(posedge clk) begin
    if (en) begin
      am3_r            <= am_prod[FRAC_W-1 +: FRAC_W];
      b16_3_r          <= b16_2_r;
      f3_r.side.grad   <= grad2_r;
      f3_r.side.glow   <= glow2_r;
      f3_r.side.fade   <= fade2_r;
      f3_r.side.weight <= '0;
      f3_r.seed        <= seed2_r;
      f3_r.low         <= low2_r;
    end
  end

  // stage 4: times bearing weight
  logic [2*FRAC_W-1:0] p_prod;
  logic                v4_r;
  front_t              f4_nxt;
  front_t              f4_r;

  assign p_prod = am3_r * b16_3_r;

  always_comb begin
    f4_nxt             = f3_r;
    f4_nxt.side.weight = p_prod[FRAC_W-1 +: FRAC_W];
  end

  always_ff @(posedge clk) begin
    if (en) begin
      f4_r <= f4_nxt;
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
      v4_r <= 1'b0;
    end else if (en) begin
      v1_r <= in_valid;
      v2_r <= v1_r;
      v3_r <= v2_r;
      v4_r <= v3_r;
    end
  end

  assign out_valid = v4_r;
  assign out_data  = f4_r;

endmodule

@@ hw/rtl/sgvc_div.sv @@
// sky gradient vertex color: pipelined restoring divider, one quotient bit per stage
// gives floor(dividend / cutoff) with the weights carried alongside; depends on sgvc_pkg

module sgvc_div import sgvc_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              en,
  input  logic              in_valid,
  input  front_t            in_data,
  input  logic [CUT_W-1:0]  cutoff,
  output logic              out_valid,
  output logic [FRAC_W-1:0] quo,
  output side_t             side
);

  div_stage_t              stg_r   [DIV_STAGES];
  div_stage_t              stg_in  [DIV_STAGES];
  div_stage_t              stg_nxt [DIV_STAGES];
  logic [FRAC_W:0]         trial   [DIV_STAGES];
  logic [DIV_STAGES-1:0]   fits;
  logic [DIV_STAGES-1:0]   vld_r, vld_in;

  // stage inputs: seed from the front end, then the previous stage
  always_comb begin
    stg_in[0].rem  = FRAC_W'(in_data.seed);
    stg_in[0].low  = in_data.low;
    stg_in[0].quo  = '0;
    stg_in[0].side = in_data.side;
    vld_in[0]      = in_valid;
    for (int k = 1; k < DIV_STAGES; k++) begin
      stg_in[k] = stg_r[k-1];
      vld_in[k] = vld_r[k-1];
    end
  end

  // shift in one dividend bit, subtract when the divisor fits
  always_comb begin
    for (int k = 0; k < DIV_STAGES; k++) begin
      trial[k]       = {stg_in[k].rem, stg_in[k].low[DIV_STAGES-1-k]};
      fits[k]        = trial[k] >= {1'b0, cutoff};
      stg_nxt[k]     = stg_in[k];
      stg_nxt[k].rem = fits[k] ? FRAC_W'(trial[k] - {1'b0, cutoff}) : trial[k][FRAC_W-1:0];
      stg_nxt[k].quo = {stg_in[k].quo[FRAC_W-2:0], fits[k]};
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      for (int k = 0; k < DIV_STAGES; k++) begin
        stg_r[k] <= stg_nxt[k];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= vld_in;
    end
  end

  assign out_valid = vld_r[DIV_STAGES-1];
  assign quo       = stg_r[DIV_STAGES-1].quo;
  assign side      = stg_r[DIV_STAGES-1].side;

endmodule

@@ hw/rtl/sgvc_blend.sv @@
// sky gradient vertex color: six-stage color blend for the three channels
// gradient mix, fade, glow mix, rounding and saturation; depends on sgvc_pkg

module sgvc_blend import sgvc_pkg::*; #(
  parameter int COLOR_BITS = COLOR_BITS_DEF
) (
  input  logic                    clk,
  input  logic                    rst_n,
  input  logic                    en,
  input  logic                    in_valid,
  input  logic [FRAC_W-1:0]       t_in,
  input  side_t                   side_in,
  input  logic [3*COLOR_BITS-1:0] horizon,
  input  logic [3*COLOR_BITS-1:0] zenith,
  input  logic [3*COLOR_BITS-1:0] glow_rgb,
  output logic                    out_valid,
  output logic [3*COLOR_BITS-1:0] out_rgb     // red, green, blue from the lowest bit up
);

  localparam int C      = COLOR_BITS;
  localparam int VW     = C + FRAC_W - 1;    // channel value scaled by 2^16
  localparam int PW     = VW + FRAC_W;       // value times fraction
  localparam int NSTAGE = 6;
  localparam logic [C-1:0] CMAX = {C{1'b1}};

  logic [C-1:0] hz_h [NUM_CH];
  logic [C-1:0] hz_z [NUM_CH];
  logic [C-1:0] gl_g [NUM_CH];

  // channel k = 0 is red, held in the top bits of a packed color
  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      hz_h[k] = horizon[C*(NUM_CH-1-k) +: C];
      hz_z[k] = zenith[C*(NUM_CH-1-k) +: C];
      gl_g[k] = glow_rgb[C*(NUM_CH-1-k) +: C];
    end
  end

  logic [NSTAGE-1:0] vld_r;
  side_t             side_r [NSTAGE-2];

  logic [VW:0]       ph_r [NUM_CH];
  logic [VW:0]       pz_r [NUM_CH];
  logic [VW-1:0]     v_r  [NUM_CH];
  logic [VW-1:0]     vf_r [NUM_CH];
  logic [VW-1:0]     vf4_r [NUM_CH];
  logic [PW-1:0]     g1_r [NUM_CH];
  logic [C+FRAC_W-1:0] g2_r [NUM_CH];
  logic [VW+1:0]     v5_r [NUM_CH];
  logic [C-1:0]      c6_r [NUM_CH];

  logic [VW:0]       sum2 [NUM_CH];
  logic [PW-1:0]     fprod3 [NUM_CH];
  logic [PW:0]       mix5 [NUM_CH];
  logic [VW+2:0]     rnd6 [NUM_CH];
  logic [C+2:0]      r6 [NUM_CH];

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      sum2[k]   = ph_r[k] + pz_r[k];
      fprod3[k] = PW'(v_r[k]) * PW'(side_r[1].fade);
      mix5[k]   = (PW+1)'(g1_r[k]) + ((PW+1)'(g2_r[k]) << (FRAC_W - 1));
      rnd6[k]   = (VW+3)'(v5_r[k]) + (VW+3)'(ROUND_HALF);
      r6[k]     = rnd6[k][FRAC_W-1 +: C+3];
    end
  end

  // datapath registers, one step per stage
  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= side_in;
      for (int s = 1; s < NSTAGE - 2; s++) begin
        side_r[s] <= side_r[s-1];
      end
      for (int k = 0; k < NUM_CH; k++) begin
        // stage 1: horizon and zenith products
        ph_r[k]  <= (VW+1)'(hz_h[k]) * (VW+1)'(ONE16 - t_in);
        pz_r[k]  <= (VW+1)'(hz_z[k]) * (VW+1)'(t_in);
        // stage 2: gradient sum, or plain zenith above the cutoff
        v_r[k]   <= side_r[0].grad ? sum2[k][VW-1:0] : {hz_z[k], {(FRAC_W-1){1'b0}}};
        // stage 3: fade
        vf_r[k]  <= fprod3[k][FRAC_W-1 +: VW];
        // stage 4: glow products
        g1_r[k]  <= PW'(vf_r[k]) * PW'(ONE16 - side_r[2].weight);
        g2_r[k]  <= (C+FRAC_W)'(gl_g[k]) * (C+FRAC_W)'(side_r[2].weight);
        vf4_r[k] <= vf_r[k];
        // stage 5: glow mix
        v5_r[k]  <= side_r[3].glow ? mix5[k][FRAC_W-1 +: VW+2] : (VW+2)'(vf4_r[k]);
        // stage 6: round and saturate
        c6_r[k]  <= (r6[k] > (C+3)'(CMAX)) ? CMAX : r6[k][C-1:0];
      end
    end
  end

  // valid bits
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r <= '0;
    end else if (en) begin
      vld_r <= {vld_r[NSTAGE-2:0], in_valid};
    end
  end

  assign out_valid = vld_r[NSTAGE-1];

  always_comb begin
    for (int k = 0; k < NUM_CH; k++) begin
      out_rgb[C*k +: C] = c6_r[k];
    end
  end

endmodule

@@ hw/rtl/sky_gradient_vertex_color.sv @@
// sky gradient vertex color: top level with config registers, pipeline and output buffer
// depends on sgvc_pkg, sgvc_cfg, sgvc_front, sgvc_div, sgvc_blend
//
//   channel   dir   handshake            payload
//   in_       in    in_tvalid/in_tready  vertex_elevation, vertex_bearing
//   out_      out   out_tvalid/out_tready red, green, blue
//   cfg_      in    cfg_valid/cfg_ready  cfg_index, cfg_data (always ready)
//
// one vertex per cycle while the output buffer is not full; an input beat reaches the
// output buffer via the 4-stage front end, 17-stage restoring divider and 6-stage blend
// reset clears the valid bits and the output buffer and loads the register defaults
// a 2-entry output buffer parts the sides; the pipeline holds only while it is full

module sky_gradient_vertex_color import sgvc_pkg::*; #(
  parameter  int COLOR_BITS = COLOR_BITS_DEF,
  parameter  int ANGLE_BITS = ANGLE_BITS_DEF,
  localparam int IN_W  = ((2 * ANGLE_BITS + 7) / 8) * 8,
  localparam int OUT_W = ((3 * COLOR_BITS + 7) / 8) * 8,
  localparam int CFG_W = (3 * COLOR_BITS > CUT_W) ? 3 * COLOR_BITS : CUT_W
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_tvalid,
  output logic                 in_tready,
  input  logic [IN_W-1:0]      in_tdata,    // vertex_elevation, vertex_bearing, zero pad
  output logic                 out_tvalid,
  input  logic                 out_tready,
  output logic [OUT_W-1:0]     out_tdata,   // red, green, blue, zero pad
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [CFG_W-1:0]     cfg_data
);

  localparam int CW = 3 * COLOR_BITS;

  logic [CW-1:0] horizon, zenith, glow_rgb;
  cfg_t          cfg;
  logic          en;

  // configuration registers
  assign cfg_ready = 1'b1;

  sgvc_cfg #(
    .COLOR_BITS (COLOR_BITS),
    .CFG_W      (CFG_W)
  ) u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .horizon   (horizon),
    .zenith    (zenith),
    .glow_rgb  (glow_rgb),
    .cfg       (cfg)
  );

  // front end
  logic   fr_valid;
  front_t fr_data;

  sgvc_front #(
    .ANGLE_BITS (ANGLE_BITS)
  ) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (in_tvalid),
    .elev      (in_tdata[ANGLE_BITS-1:0]),
    .bear      (in_tdata[2*ANGLE_BITS-1:ANGLE_BITS]),
    .cfg       (cfg),
    .out_valid (fr_valid),
    .out_data  (fr_data)
  );

  // gradient position divider
  logic              dv_valid;
  logic [FRAC_W-1:0] dv_quo;
  side_t             dv_side;

  sgvc_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (fr_valid),
    .in_data   (fr_data),
    .cutoff    (cfg.cutoff),
    .out_valid (dv_valid),
    .quo       (dv_quo),
    .side      (dv_side)
  );

  // color blend
  logic          bl_valid;
  logic [CW-1:0] bl_rgb;

  sgvc_blend #(
    .COLOR_BITS (COLOR_BITS)
  ) u_blend (
    .clk       (clk),
    .rst_n     (rst_n),
    .en        (en),
    .in_valid  (dv_valid),
    .t_in      (dv_quo),
    .side_in   (dv_side),
    .horizon   (horizon),
    .zenith    (zenith),
    .glow_rgb  (glow_rgb),
    .out_valid (bl_valid),
    .out_rgb   (bl_rgb)
  );

  // two-entry output buffer
  logic [1:0]    cnt_r, cnt_nxt;
  logic [CW-1:0] head_r, tail_r;
  logic          push, pop;

  assign en        = cnt_r != 2'd2;
  assign in_tready = en;
  assign push      = en & bl_valid;
  assign pop       = out_tvalid & out_tready;

  always_comb begin
    cnt_nxt = cnt_r + 2'(push) - 2'(pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r <= '0;
    end else begin
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      if (cnt_r == 2'd2) begin
        head_r <= tail_r;
      end else if (push) begin
        head_r <= bl_rgb;
      end
    end else if (push) begin
      if (cnt_r == 2'd0) begin
        head_r <= bl_rgb;
      end else begin
        tail_r <= bl_rgb;
      end
    end
  end

  assign out_tvalid = cnt_r != 2'd0;
  assign out_tdata  = OUT_W'(head_r);

endmodule

@@ tb/sv/tb_sky_gradient_vertex_color.sv @@
// self-checking testbench for sky_gradient_vertex_color: vertices in, predicted sky colors out
// a local color predictor runs beside the block; results are compared in arrival order
// depends on sgvc_pkg and the sky_gradient_vertex_color top level

module tb_sky_gradient_vertex_color;
  import sgvc_pkg::*;

  localparam int VERT_W      = ((2 * ANGLE_BITS_DEF + 7) / 8) * 8;
  localparam int RGB_W       = ((3 * COLOR_BITS_DEF + 7) / 8) * 8;
  localparam int REG_DATA_W  = (3 * COLOR_BITS_DEF > CUT_W) ? 3 * COLOR_BITS_DEF : CUT_W;
  localparam longint RIGHT_ANGLE = longint'(1) << (ANGLE_BITS_DEF - 2);
  localparam longint CHAN_MAX    = (longint'(1) << COLOR_BITS_DEF) - 1;
  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 400;
  localparam int DRAIN_PAUSE = 40;
  localparam int MAX_PRINTS  = 40;

  // register indexes past the end of the map, written to show they are ignored
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

  typedef struct {
    logic [23:0]      horizon;
    logic [23:0]      zenith;
    logic [23:0]      glow;
    logic [CUT_W-1:0] cutoff;
    logic [ALT_W-1:0] sun_alt;
    logic [AZI_W-1:0] sun_azi;
  } sky_setting_t;

  typedef struct {
    logic [COLOR_BITS_DEF-1:0] red;
    logic [COLOR_BITS_DEF-1:0] green;
    logic [COLOR_BITS_DEF-1:0] blue;
  } rgb_t;

  logic                  clk = 1'b0;
  logic                  rst_n = 1'b0;
  logic                  in_tvalid = 1'b0;
  logic                  in_tready;
  logic [VERT_W-1:0]     in_tdata = '0;    // vertex_elevation, vertex_bearing
  logic                  out_tvalid;
  logic                  out_tready = 1'b0;
  logic [RGB_W-1:0]      out_tdata;        // red, green, blue
  logic                  cfg_valid = 1'b0;
  logic                  cfg_ready;
  logic [CFG_IDX_W-1:0]  cfg_index = '0;
  logic [REG_DATA_W-1:0] cfg_data = '0;

  sky_setting_t sky_cfg;
  rgb_t         color_due[$];
  int           send_idle_pct = 0;
  int           recv_stall_pct = 0;
  int           hold_req_cnt = 0;
  int           hold_seen_cnt = 0;
  int           hold_left = 0;
  int           cycle_count = 0;
  int           error_count = 0;
  int           vertex_count = 0;
  int           colors_checked = 0;
  int           settings_count = 0;

  sky_gradient_vertex_color i_dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .cfg_valid  (cfg_valid),
    .cfg_ready  (cfg_ready),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data)
  );

  // clock
  initial begin
    forever #4 clk = ~clk;
  end

  // expected color of one vertex under the current register setting
  function automatic rgb_t sky_color_of(input logic [15:0] elev, input logic [15:0] bear);
    longint e, b, alt, ae, ab, aa, dd, u, c, t, fade, p, w;
    longint a16, m16, b16, v, h, z, g, one, twi, night, sunset;
    bit     in_grad, in_glow;
    rgb_t   res;
    one    = ONE16;
    twi    = TWI_LIMIT;
    night  = NIGHT_FADE;
    sunset = SUNSET_AZI;
    e   = $signed(elev);
    b   = $signed(bear);
    alt = $signed(sky_cfg.sun_alt);
    ae  = (e < 0) ? -e : e;
    ab  = (b < 0) ? -b : b;
    aa  = (alt < 0) ? -alt : alt;
    // fold the elevation into 0..right angle
    dd  = RIGHT_ANGLE - ae;
    if (dd < 0) dd = -dd;
    u   = RIGHT_ANGLE - dd;

    // position inside the horizon to zenith gradient
    c = (sky_cfg.cutoff == 0) ? 1 : longint'(sky_cfg.cutoff);
    in_grad = (u * one) <= (c * RIGHT_ANGLE);
    t = in_grad ? (u << 32) / (c * RIGHT_ANGLE) : 0;

    // day, night and twilight fade
    if (alt < -twi) fade = night;
    else if (alt > twi) fade = one;
    else fade = night + ((one - night) * (alt + twi)) / (2 * twi);

    // glow weight on the sunset or sunrise half
    in_glow = 1'b0;
    p = 0;
    w = 0;
    if (aa <= twi && 2 * u <= RIGHT_ANGLE) begin
      if (longint'(sky_cfg.sun_azi) > sunset) begin
        if (ab > RIGHT_ANGLE) begin
          in_glow = 1'b1;
          w = ab - RIGHT_ANGLE;
        end
      end else if (ab <= RIGHT_ANGLE) begin
        in_glow = 1'b1;
        w = RIGHT_ANGLE - ab;
      end
      if (in_glow) begin
        a16 = ((RIGHT_ANGLE - 2 * u) * one) / RIGHT_ANGLE;
        m16 = ((twi - aa) * one) / twi;
        b16 = (w * one) / RIGHT_ANGLE;
        p   = (((a16 * m16) >> 16) * b16) >> 16;
      end
    end

    // per channel blend, red in the top byte of the packed colors
    for (int k = 0; k < NUM_CH; k++) begin
      h = (sky_cfg.horizon >> (COLOR_BITS_DEF * (2 - k))) & CHAN_MAX;
      z = (sky_cfg.zenith >> (COLOR_BITS_DEF * (2 - k))) & CHAN_MAX;
      g = (sky_cfg.glow >> (COLOR_BITS_DEF * (2 - k))) & CHAN_MAX;
      v = in_grad ? h * (one - t) + z * t : z * one;
      v = (v * fade) >> 16;
      if (in_glow) v = (v * (one - p) + g * one * p) >> 16;
      v = (v + 32768) >> 16;
      if (v > CHAN_MAX) v = CHAN_MAX;
      case (k)
        0: res.red   = v[COLOR_BITS_DEF-1:0];
        1: res.green = v[COLOR_BITS_DEF-1:0];
        default: res.blue = v[COLOR_BITS_DEF-1:0];
      endcase
    end
    return res;
  endfunction

  function automatic sky_setting_t sky_setting(input logic [23:0] h, input logic [23:0] z,
                                               input logic [23:0] g, input logic [CUT_W-1:0] cut,
                                               input logic [ALT_W-1:0] alt,
                                               input logic [AZI_W-1:0] azi);
    sky_setting_t s;
    s.horizon = h;
    s.zenith  = z;
    s.glow    = g;
    s.cutoff  = cut;
    s.sun_alt = alt;
    s.sun_azi = azi;
    return s;
  endfunction

  // random setting, biased toward the twilight band and the sunset/sunrise boundary
  function automatic sky_setting_t random_sky();
    sky_setting_t s;
    s.horizon = 24'($urandom);
    s.zenith  = 24'($urandom);
    s.glow    = 24'($urandom);
    case ($urandom_range(9))
      0: s.cutoff = '0;
      1: s.cutoff = 17'($urandom_range(131071, 65537));
      default: s.cutoff = 17'($urandom_range(65536, 1));
    endcase
    case ($urandom_range(3))
      0: s.sun_alt = 16'($urandom);
      1: s.sun_alt = 16'(int'($urandom_range(46080)) - 23040);
      default: s.sun_alt = 16'(int'($urandom_range(3000)) - 1500);
    endcase
    case ($urandom_range(4))
      0: s.sun_azi = 17'($urandom);
      1: s.sun_azi = 17'(46079 + $urandom_range(2));
      default: s.sun_azi = 17'($urandom_range(92159));
    endcase
    return s;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    if (error_count < MAX_PRINTS)
      $display("[%0d] mismatch on %s: got %0d, expected %0d", cycle_count, what, got, want);
    error_count++;
  endtask

  // one register beat; the local copy follows the write
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [REG_DATA_W-1:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    do @(posedge clk); while (!cfg_ready);
    case (idx)
      REG_HORIZON: sky_cfg.horizon = data[23:0];
      REG_ZENITH:  sky_cfg.zenith  = data[23:0];
      REG_GLOW:    sky_cfg.glow    = data[23:0];
      REG_CUTOFF:  sky_cfg.cutoff  = data[CUT_W-1:0];
      REG_SUN_ALT: sky_cfg.sun_alt = data[ALT_W-1:0];
      REG_SUN_AZI: sky_cfg.sun_azi = data[AZI_W-1:0];
      default: ;
    endcase
  endtask

  // write every register, junk in the unused upper data bits, plus one unmapped index
  task automatic program_sky(input sky_setting_t s);
    write_reg(REG_HORIZON, s.horizon);
    write_reg(REG_ZENITH, s.zenith);
    write_reg(REG_GLOW, s.glow);
    write_reg(REG_CUTOFF, {7'($urandom), s.cutoff});
    write_reg(REG_SUN_ALT, {8'($urandom), s.sun_alt});
    write_reg(REG_SUN_AZI, {7'($urandom), s.sun_azi});
    write_reg($urandom_range(1) ? REG_SPARE_HI : REG_SPARE_LO, 24'($urandom));
    cfg_valid <= 1'b0;
    settings_count++;
  endtask

  // one vertex beat with an optional gap ahead of it
  task automatic send_vertex(input logic [15:0] elev, input logic [15:0] bear);
    if ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      do @(posedge clk); while ($urandom_range(99) < send_idle_pct);
    end
    in_tvalid <= 1'b1;
    in_tdata  <= {bear, elev};
    do @(posedge clk); while (!in_tready);
    color_due.insert(color_due.size(), sky_color_of(elev, bear));
    vertex_count++;
  endtask

  task automatic send_random_vertex();
    logic [15:0] elev;
    case ($urandom_range(7))
      0: elev = 16'($urandom);
      1, 2: elev = 16'(int'($urandom_range(16384)) - 8192);
      default: elev = 16'(int'($urandom_range(32768)) - 16384);
    endcase
    send_vertex(elev, 16'($urandom));
  endtask

  // stop offering and wait until every pending color has come back
  task automatic drain_colors();
    in_tvalid <= 1'b0;
    do @(posedge clk); while (color_due.size() != 0);
  endtask

  // reset values, register extremes and the named corner cases
  task automatic test_directed();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    // register defaults straight after reset, sunrise glow at zero altitude
    send_vertex(16'sd0, 16'sd0);
    send_vertex(16'sd16384, -16'sd32768);
    send_vertex(-16'sd16384, 16'sd32767);
    send_vertex(16'sd4096, 16'sd16384);
    send_vertex(16'sd32767, -16'sd16384);
    drain_colors();
    // zero cutoff, deepest night, white to black
    program_sky(sky_setting(24'hFFFFFF, 24'h000000, 24'hFFFFFF, 17'd0, -16'sd23040, 17'd0));
    send_vertex(16'sd1, 16'sd0);
    send_vertex(16'sd0, 16'sd0);
    send_vertex(16'sd8192, 16'sd100);
    send_vertex(-16'sd32768, -16'sd32768);
    drain_colors();
    // cutoff beyond one, full day, largest azimuth
    program_sky(sky_setting(24'h000000, 24'hFFFFFF, 24'h000000, 17'd131071, 16'sd23040,
                            17'd92159));
    send_vertex(16'sd16384, 16'sd0);
    send_vertex(-16'sd16384, 16'sd32767);
    send_vertex(16'sd12000, 16'sd5);
    drain_colors();
    // sunset glow, both sides of the west/east split
    program_sky(sky_setting(24'h808080, 24'h204080, 24'hFF8000, 17'd65536, 16'sd640,
                            17'd46081));
    send_vertex(16'sd0, -16'sd32768);
    send_vertex(16'sd0, 16'sd32767);
    send_vertex(16'sd2000, 16'sd20000);
    send_vertex(16'sd0, 16'sd16384);
    send_vertex(16'sd0, 16'sd16385);
    drain_colors();
    // sunrise at the azimuth boundary, glow just past its elevation limit
    program_sky(sky_setting(24'h10E0A0, 24'hFF0000, 24'h00FF00, 17'd65535, -16'sd600,
                            17'd46080));
    send_vertex(16'sd0, 16'sd0);
    send_vertex(16'sd0, 16'sd16384);
    send_vertex(16'sd0, -16'sd16384);
    send_vertex(16'sd8192, 16'sd0);
    send_vertex(16'sd8193, 16'sd0);
    drain_colors();
    // altitude and azimuth beyond their ranges, smallest nonzero cutoff
    program_sky(sky_setting(24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 17'd1, 16'h8000, 17'h1FFFF));
    send_vertex(16'sd100, -16'sd30000);
    drain_colors();
    program_sky(sky_setting(24'hFFFFFF, 24'h000000, 24'h0000FF, 17'd1, 16'h7FFF, 17'h1FFFF));
    send_vertex(16'sd0, 16'sd0);
    drain_colors();
  endtask

  // random vertices in chunks, a fresh random setting per chunk
  task automatic test_random_phase(input int n_items, input int send_pct, input int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
    for (int i = 0; i < n_items; i++) begin
      if (i % 50 == 0) begin
        drain_colors();
        program_sky(random_sky());
      end
      send_random_vertex();
    end
    drain_colors();
  endtask

  // receiver holds off for a long stretch while vertices keep coming
  task automatic test_backpressure();
    send_idle_pct  = 0;
    recv_stall_pct = 0;
    drain_colors();
    program_sky(random_sky());
    hold_req_cnt++;
    for (int i = 0; i < 80; i++) send_random_vertex();
    drain_colors();
  endtask

  // result side: random stalls, plus the long hold when requested
  always @(posedge clk) begin
    if (hold_seen_cnt != hold_req_cnt) begin
      hold_seen_cnt <= hold_req_cnt;
      hold_left     <= HOLD_CYCLES;
      out_tready    <= 1'b0;
    end else if (hold_left != 0) begin
      hold_left  <= hold_left - 1;
      out_tready <= 1'b0;
    end else begin
      out_tready <= ($urandom_range(99) >= recv_stall_pct);
    end
  end

  // compare each result beat against the oldest pending color
  always @(posedge clk) begin
    rgb_t got;
    rgb_t want;
    if (rst_n && out_tvalid && out_tready) begin
      got.red   = out_tdata[0 +: COLOR_BITS_DEF];
      got.green = out_tdata[COLOR_BITS_DEF +: COLOR_BITS_DEF];
      got.blue  = out_tdata[2 * COLOR_BITS_DEF +: COLOR_BITS_DEF];
      if (color_due.size() == 0) begin
        report_mismatch("unexpected result beat, red", got.red, -1);
      end else begin
        want = color_due.pop_front();
        if (got.red != want.red) report_mismatch("red", got.red, want.red);
        if (got.green != want.green) report_mismatch("green", got.green, want.green);
        if (got.blue != want.blue) report_mismatch("blue", got.blue, want.blue);
        colors_checked++;
      end
    end
  end

  // run limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d colors still pending", cycle_count,
               color_due.size());
      $display("Testbench completed WITH ERRORS");
      $finish;
    end
  end

  // test sequence
  initial begin
    sky_cfg = sky_setting(HORIZON_RST, ZENITH_RST, GLOW_RST, CUTOFF_RST, '0, '0);
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);
    test_directed();
    test_random_phase(125, 0, 0);
    test_random_phase(125, 78, 0);
    test_random_phase(125, 0, 78);
    test_random_phase(125, 33, 33);
    test_backpressure();
    drain_colors();
    repeat (DRAIN_PAUSE) @(posedge clk);
    $display("sent %0d vertices under %0d register settings, %0d colors checked",
             vertex_count, settings_count, colors_checked);
    $display("covered day, night and twilight fades, sunrise and sunset glow, stalls on both sides");
    if (error_count == 0 && color_due.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule
